// File: rtl/core/outlier_gated_moving_average_unit_defines.svh
// ============================================================================
// Outlier-gated moving average unit: assertion macros
// Shared concurrent assertion forms for the unit's checks.
// ============================================================================
`ifndef OUTLIER_GATED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define OUTLIER_GATED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define OGMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define OGMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ogma_pkg.sv
// ============================================================================
// ogma_pkg
// Fixed widths, reset values and helpers of the outlier-gated moving average.
// ============================================================================
package ogma_pkg;

    // fixed field widths
    localparam int ANGLE_W = 16;
    localparam int CHAN_IN_W = 2;

    typedef logic [ANGLE_W-1:0] t_angle;
    typedef logic [CHAN_IN_W-1:0] t_chan;
    typedef logic [ANGLE_W:0] t_mag;

    // threshold after reset
    localparam t_angle MAX_CHANGE_RST = 16'd500;

    // magnitude of the wrapped signed 16-bit difference a - b, 0..32768
    function automatic t_mag wrapped_mag(input t_angle a, input t_angle b);
        t_angle diff;
        diff = a - b;
        if (diff[ANGLE_W-1]) begin
            return 17'h10000 - {1'b0, diff};
        end
        return {1'b0, diff};
    endfunction

endpackage

// File: rtl/core/ogma_ram.sv
// ============================================================================
// ogma_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module ogma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and read-first registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/outlier_gated_moving_average_unit.sv
// ============================================================================
// Outlier-gated moving average unit
// Per-channel outlier rejection followed by a sliding-window mean.
// ============================================================================
// Each request carries a channel and a raw angle. A sample whose wrapped jump
// from the channel's last good value exceeds max_change (and whose last good
// value is nonzero) is replaced by that last good value and flagged rejected;
// the chosen value enters the channel's window of WINDOW samples and the
// result is the truncated window mean. Channels at or above CHANNELS leave the
// state alone and return a zero mean. The unit takes one request per cycle
// sustained, back to back on any channel, while results are taken; the
// state and window RAM reads are issued at the accepting edge, the outlier
// test and running sum update with write-back act on their data, and the
// mean is a reciprocal multiply split into two partial products in stage 3
// and their sum in the output register. A result waiting at the output
// does not block the next request while the pipeline has room. State is
// empty right after reset, with no clearing pass: per channel valid bits and
// window fill flags stand for the cleared contents. max_change may only be
// written while no request is in flight.
module outlier_gated_moving_average_unit
    import ogma_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int CHANNELS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // sample requests
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_channel,
    input  logic [15:0]   i_raw_angle,
    // filtered results
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_out_channel,
    output logic [15:0]   o_filtered_angle,
    output logic          o_rejected,
    // threshold register
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata
);

    // derived sizes
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = ANGLE_W + LOG_W;
    localparam int CS_W   = ANGLE_W + SUM_W;
    localparam int WDEPTH = CHANNELS * WINDOW;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    // exact floor division by WINDOW through a rounded-up reciprocal
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int M_W    = SUM_W + 1;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [M_W-1:0] RECIP = RECIP64[M_W-1:0];
    localparam int H      = SUM_W / 2;
    localparam int LO_P   = H + M_W;
    localparam int HI_P   = (SUM_W - H) + M_W;
    localparam int TOT_W  = SUM_W + M_W;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
    localparam logic [4:0]       NCH      = 5'(CHANNELS);

    // threshold register
    t_angle r_max_change;

    // per-channel write position and fill flag
    logic [POS_W-1:0] r_pos  [CHANNELS];
    logic             r_wrap [CHANNELS];
    logic [CHANNELS-1:0] r_cs_valid;

    // stage 1: ram data arriving
    logic             r_s1_valid;
    t_chan            r_s1_chan;
    logic             r_s1_good;
    logic [CH_W-1:0]  r_s1_idx;
    t_angle           r_s1_sample;
    logic             r_s1_wrap;
    logic [WA_W-1:0]  r_s1_waddr;

    // stage 2: updated sum
    logic             r_s2_valid;
    t_chan            r_s2_chan;
    logic             r_s2_rej;
    logic [SUM_W-1:0] r_s2_sum;

    // stage 3: partial products
    logic             r_s3_valid;
    t_chan            r_s3_chan;
    logic             r_s3_rej;
    logic [LO_P-1:0]  r_s3_plo;
    logic [HI_P-1:0]  r_s3_phi;

    // output register
    logic             r_o_valid;
    t_chan            r_o_chan;
    logic             r_o_rej;
    t_angle           r_o_mean;

    // last write, forwarded to the following read
    logic             r_fw_valid;
    logic [CH_W-1:0]  r_fw_idx;
    t_angle           r_fw_lg;
    logic [SUM_W-1:0] r_fw_sum;
    logic [WA_W-1:0]  r_fw_waddr;
    t_angle           r_fw_wdata;

    logic             rdy_o, rdy3, rdy2, rdy1;
    logic             acc, s1_fire;
    logic             in_good;
    logic [CH_W-1:0]  in_idx;
    logic [POS_W-1:0] in_pos;
    logic [WA_W-1:0]  in_waddr;

    logic [CS_W-1:0]  cs_rdata, cs_wdata;
    t_angle           win_rdata;

    t_angle           s1_lg;
    logic [SUM_W-1:0] s1_sum;
    t_angle           s1_old;
    logic             s1_rej;
    t_angle           n_lg;
    t_angle           s1_chosen;
    logic [SUM_W-1:0] n_sum;

    logic [TOT_W-1:0] s3_total;

    // stall chain, each stage moves when the one after it has room
    assign rdy_o   = !r_o_valid || i_ready;
    assign rdy3    = !r_s3_valid || rdy_o;
    assign rdy2    = !r_s2_valid || rdy3;
    assign rdy1    = !r_s1_valid || rdy2;
    assign o_ready = rdy1;
    assign acc     = i_valid && rdy1;
    assign s1_fire = r_s1_valid && rdy2;

    // request decode and window address
    assign in_good  = {3'b000, i_channel} < NCH;
    assign in_idx   = CH_W'(i_channel);
    assign in_pos   = in_good ? r_pos[in_idx] : '0;
    assign in_waddr = WA_W'(in_idx) * WA_W'(WINDOW) + WA_W'(in_pos);

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_change <= MAX_CHANGE_RST;
        end else if (i_cfg_we) begin
            r_max_change <= i_cfg_wdata;
        end
    end

    // write position advances as the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c]  <= '0;
                r_wrap[c] <= 1'b0;
            end
        end else if (acc && in_good) begin
            if (in_pos == POS_LAST) begin
                r_pos[in_idx]  <= '0;
                r_wrap[in_idx] <= 1'b1;
            end else begin
                r_pos[in_idx] <= in_pos + 1'b1;
            end
        end
    end

    // channel state ram: last good value and running sum
    ogma_ram #(
        .WIDTH (CS_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire && r_s1_good),
        .i_waddr (r_s1_idx),
        .i_wdata (cs_wdata),
        .i_re    (acc),
        .i_raddr (in_idx),
        .o_rdata (cs_rdata)
    );

    // window ram, WINDOW slots per channel
    ogma_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (WDEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire && r_s1_good),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_chosen),
        .i_re    (acc),
        .i_raddr (in_waddr),
        .o_rdata (win_rdata)
    );

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rdy1) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_chan   <= i_channel;
            r_s1_good   <= in_good;
            r_s1_idx    <= in_idx;
            r_s1_sample <= i_raw_angle;
            r_s1_wrap   <= in_good ? r_wrap[in_idx] : 1'b0;
            r_s1_waddr  <= in_waddr;
        end
    end

    // read data with forwarding from the latest write, empty entries read zero
    always_comb begin
        if (r_fw_valid && r_fw_idx == r_s1_idx) begin
            s1_lg  = r_fw_lg;
            s1_sum = r_fw_sum;
        end else if (r_cs_valid[r_s1_idx]) begin
            s1_lg  = cs_rdata[CS_W-1:SUM_W];
            s1_sum = cs_rdata[SUM_W-1:0];
        end else begin
            s1_lg  = '0;
            s1_sum = '0;
        end
        if (r_fw_valid && r_fw_waddr == r_s1_waddr) begin
            s1_old = r_fw_wdata;
        end else if (r_s1_wrap) begin
            s1_old = win_rdata;
        end else begin
            s1_old = '0;
        end
    end

    // outlier test and running sum update
    assign s1_rej    = (wrapped_mag(r_s1_sample, s1_lg) > {1'b0, r_max_change})
                       && (s1_lg != '0);
    assign s1_chosen = s1_rej ? s1_lg : r_s1_sample;
    assign n_lg      = s1_chosen;
    assign n_sum     = s1_sum - SUM_W'(s1_old) + SUM_W'(s1_chosen);
    assign cs_wdata  = {n_lg, n_sum};

    // entry valid bits and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_valid <= '0;
            r_fw_valid <= 1'b0;
        end else if (s1_fire && r_s1_good) begin
            r_cs_valid[r_s1_idx] <= 1'b1;
            r_fw_valid           <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_good) begin
            r_fw_idx   <= r_s1_idx;
            r_fw_lg    <= n_lg;
            r_fw_sum   <= n_sum;
            r_fw_waddr <= r_s1_waddr;
            r_fw_wdata <= s1_chosen;
        end
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_chan <= r_s1_chan;
            r_s2_rej  <= r_s1_good && s1_rej;
            r_s2_sum  <= r_s1_good ? n_sum : '0;
        end
    end

    // stage 3: reciprocal multiply in two partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (rdy3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_valid) begin
            r_s3_chan <= r_s2_chan;
            r_s3_rej  <= r_s2_rej;
            r_s3_plo  <= LO_P'(r_s2_sum[H-1:0]) * LO_P'(RECIP);
            r_s3_phi  <= HI_P'(r_s2_sum[SUM_W-1:H]) * HI_P'(RECIP);
        end
    end

    // combine partial products and drop the fraction
    assign s3_total = (TOT_W'(r_s3_phi) << H) + TOT_W'(r_s3_plo);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (rdy_o) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o && r_s3_valid) begin
            r_o_chan <= r_s3_chan;
            r_o_rej  <= r_s3_rej;
            r_o_mean <= s3_total[SHIFT +: ANGLE_W];
        end
    end

    assign o_valid          = r_o_valid;
    assign o_out_channel    = r_o_chan;
    assign o_filtered_angle = r_o_mean;
    assign o_rejected       = r_o_rej;

    // checks
`include "outlier_gated_moving_average_unit_defines.svh"

    `OGMA_ASSERT_NOW(a_accept_has_room, i_clk, i_rst_n, i_valid && o_ready, !r_s1_valid || s1_fire, "request taken while stage 1 holds an item")
    `OGMA_ASSERT_NEXT(a_s1_moves_on, i_clk, i_rst_n, s1_fire, r_s2_valid, "stage 1 item lost on its way to stage 2")
    `OGMA_ASSERT_NOW(a_bad_chan_zero, i_clk, i_rst_n, o_valid && ({3'b000, o_out_channel} >= NCH), (o_filtered_angle == '0) && !o_rejected, "result for an unused channel is not zero")

endmodule
